[hw/rtl/one_shot_deadline_merger_unit_macros.svh]
// ---------------------------------------------------------------------------
// One-shot deadline merger assertion macros
// Shared concurrent assertion forms for the deadline merger checkers.
// ---------------------------------------------------------------------------
`ifndef ONE_SHOT_DEADLINE_MERGER_UNIT_MACROS_SVH
`define ONE_SHOT_DEADLINE_MERGER_UNIT_MACROS_SVH

// same-cycle implication
`define OSDM_ASSERT_IMPLIES(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("osdm: implication failed");

// next-cycle implication
`define OSDM_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("osdm: next-cycle implication failed");

`endif

[hw/rtl/osdm_pkg.sv]
// ---------------------------------------------------------------------------
// osdm_pkg
// Types and constants shared by the one-shot deadline merger modules.
// ---------------------------------------------------------------------------
`default_nettype none

package osdm_pkg;

  localparam int TIME_W = 64;
  localparam int SEQ_W  = 32;

  typedef enum logic [1:0] {
    OP_PUB_TMR = 2'd0,
    OP_PUB_PRE = 2'd1,
    OP_BEGIN   = 2'd2,
    OP_END     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NESTED  = 2'd1,
    ST_BAD_END = 2'd2
  } status_t;

  typedef struct packed {
    op_t               op;
    logic              deadline_armed;
    logic [TIME_W-1:0] deadline_when;
    logic [TIME_W-1:0] now_time;
    logic [SEQ_W-1:0]  session_seq;
  } req_t;

  typedef struct packed {
    logic              write_comparator;
    logic              comparator_armed;
    logic [TIME_W-1:0] comparator_when;
    logic [SEQ_W-1:0]  new_seq;
    logic              timer_due;
    logic              preempt_due;
    status_t           status;
    logic              live_armed;
    logic [TIME_W-1:0] live_when;
  } rsp_t;

endpackage

`default_nettype wire

[hw/rtl/osdm_merge.sv]
// ---------------------------------------------------------------------------
// osdm_merge
// Picks the earlier of the armed timer and preempt deadlines; timer wins ties.
// ---------------------------------------------------------------------------
`default_nettype none

module osdm_merge #(
  parameter int TIME_BITS = 64
) (
  input  wire logic                 tmr_armed,
  input  wire logic [TIME_BITS-1:0] tmr_when,
  input  wire logic                 pre_armed,
  input  wire logic [TIME_BITS-1:0] pre_when,
  output logic                      armed,
  output logic [TIME_BITS-1:0]      when
);

  always_comb begin
    if (tmr_armed && (!pre_armed || tmr_when <= pre_when)) begin
      armed = tmr_armed;
      when  = tmr_when;
    end else begin
      armed = pre_armed;
      when  = pre_when;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/osdm_core.sv]
// ---------------------------------------------------------------------------
// osdm_core
// Deadline, comparator and session state; computes one result per step.
// ---------------------------------------------------------------------------
`default_nettype none

module osdm_core #(
  parameter int TIME_BITS = 64,
  parameter int SEQ_BITS  = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire osdm_pkg::req_t req,
  output osdm_pkg::rsp_t     rsp
);

  localparam int TW  = osdm_pkg::TIME_W;
  localparam int SW  = osdm_pkg::SEQ_W;
  localparam int SIN = (SEQ_BITS < SW) ? SEQ_BITS : SW;

  logic                 tmr_armed, tmr_armed_next;
  logic [TIME_BITS-1:0] tmr_when, tmr_when_next;
  logic                 pre_armed, pre_armed_next;
  logic [TIME_BITS-1:0] pre_when, pre_when_next;
  logic                 prog_armed, prog_armed_next;
  logic [TIME_BITS-1:0] prog_when, prog_when_next;
  logic                 prog_valid, prog_valid_next;
  logic                 in_session, in_session_next;
  logic [SEQ_BITS-1:0]  seq_count, seq_count_next;

  logic                 pub_armed;
  logic [TIME_BITS-1:0] pub_when;
  logic [TIME_BITS-1:0] now;
  logic [SEQ_BITS-1:0]  sseq;
  logic [SEQ_BITS-1:0]  seq_inc;
  logic                 m_armed;
  logic [TIME_BITS-1:0] m_when;

  assign pub_armed = req.deadline_armed;
  assign pub_when  = req.deadline_armed ? req.deadline_when[TIME_BITS-1:0] : '0;
  assign now       = req.now_time[TIME_BITS-1:0];
  assign sseq      = SEQ_BITS'(req.session_seq[SIN-1:0]);
  assign seq_inc   = seq_count + SEQ_BITS'(1);

  osdm_merge #(
    .TIME_BITS (TIME_BITS)
  ) u_merge (
    .tmr_armed (tmr_armed_next),
    .tmr_when  (tmr_when_next),
    .pre_armed (pre_armed_next),
    .pre_when  (pre_when_next),
    .armed     (m_armed),
    .when      (m_when)
  );

  always_comb begin
    tmr_armed_next  = tmr_armed;
    tmr_when_next   = tmr_when;
    pre_armed_next  = pre_armed;
    pre_when_next   = pre_when;
    if (req.op == osdm_pkg::OP_PUB_TMR) begin
      tmr_armed_next = pub_armed;
      tmr_when_next  = pub_when;
    end
    if (req.op == osdm_pkg::OP_PUB_PRE) begin
      pre_armed_next = pub_armed;
      pre_when_next  = pub_when;
    end
  end

  always_comb begin
    prog_armed_next      = prog_armed;
    prog_when_next       = prog_when;
    prog_valid_next      = prog_valid;
    in_session_next      = in_session;
    seq_count_next       = seq_count;
    rsp.write_comparator = 1'b0;
    rsp.comparator_armed = 1'b0;
    rsp.comparator_when  = '0;
    rsp.timer_due        = 1'b0;
    rsp.preempt_due      = 1'b0;
    rsp.status           = osdm_pkg::ST_OK;
    case (req.op)
      osdm_pkg::OP_PUB_TMR, osdm_pkg::OP_PUB_PRE: begin
        if (!in_session &&
            !(prog_valid && prog_armed == m_armed && prog_when == m_when)) begin
          rsp.write_comparator = 1'b1;
          rsp.comparator_armed = m_armed;
          rsp.comparator_when  = TW'(m_when);
          prog_armed_next      = m_armed;
          prog_when_next       = m_when;
          prog_valid_next      = 1'b1;
        end
      end
      osdm_pkg::OP_BEGIN: begin
        if (in_session) begin
          rsp.status = osdm_pkg::ST_NESTED;
        end else begin
          rsp.write_comparator = 1'b1;
          prog_valid_next      = 1'b0;
          in_session_next      = 1'b1;
          seq_count_next       = (seq_inc == '0) ? SEQ_BITS'(1) : seq_inc;
          rsp.timer_due        = tmr_armed && (tmr_when <= now);
          rsp.preempt_due      = pre_armed && (pre_when <= now);
        end
      end
      osdm_pkg::OP_END: begin
        if (!in_session || sseq != seq_count) begin
          rsp.status = osdm_pkg::ST_BAD_END;
        end else begin
          in_session_next      = 1'b0;
          rsp.write_comparator = 1'b1;
          rsp.comparator_armed = m_armed;
          rsp.comparator_when  = TW'(m_when);
          prog_armed_next      = m_armed;
          prog_when_next       = m_when;
          prog_valid_next      = 1'b1;
        end
      end
      default: begin
        rsp.status = osdm_pkg::ST_OK;
      end
    endcase
    rsp.new_seq    = SW'(seq_count_next);
    rsp.live_armed = prog_valid_next & prog_armed_next;
    rsp.live_when  = prog_valid_next ? TW'(prog_when_next) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tmr_armed  <= 1'b0;
      tmr_when   <= '0;
      pre_armed  <= 1'b0;
      pre_when   <= '0;
      prog_armed <= 1'b0;
      prog_when  <= '0;
      prog_valid <= 1'b1;
      in_session <= 1'b0;
      seq_count  <= '0;
    end else if (step) begin
      tmr_armed  <= tmr_armed_next;
      tmr_when   <= tmr_when_next;
      pre_armed  <= pre_armed_next;
      pre_when   <= pre_when_next;
      prog_armed <= prog_armed_next;
      prog_when  <= prog_when_next;
      prog_valid <= prog_valid_next;
      in_session <= in_session_next;
      seq_count  <= seq_count_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/one_shot_deadline_merger_unit.sv]
// ---------------------------------------------------------------------------
// one_shot_deadline_merger_unit
// Merges a timer and a preempt one-shot deadline onto one comparator.
// ---------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall/req) carries one event per transaction:
//   publish timer, publish preempt, begin interrupt or end interrupt.
//   rsp channel (rsp_valid/rsp_stall/rsp) returns exactly one result per
//   event, in order: comparator write, sequence, due flags, status and the
//   currently programmed deadline.
//   An accepted request reaches rsp_valid through one input register, then
//   the state update and result register. Throughput is one transaction per
//   cycle while rsp_stall holds no result, limited by the state update.
//   When rsp_stall holds a result, one more request is taken into the input
//   register, after which req_stall rises until the result is taken.
//   Reset (rst, synchronous) clears both deadlines, leaves the comparator
//   programmed disarmed, closes any session and zeroes the sequence.
// ---------------------------------------------------------------------------
`default_nettype none

module one_shot_deadline_merger_unit #(
  parameter int TIME_BITS = 64,
  parameter int SEQ_BITS  = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire osdm_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output osdm_pkg::rsp_t      rsp
);

  logic           s1_valid;
  osdm_pkg::req_t s1_req;
  osdm_pkg::rsp_t core_rsp;
  logic           adv;

  assign adv       = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!req_stall) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      s1_req <= req;
    end
  end

  osdm_core #(
    .TIME_BITS (TIME_BITS),
    .SEQ_BITS  (SEQ_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .step (adv),
    .req  (s1_req),
    .rsp  (core_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (!rsp_valid || !rsp_stall) begin
      rsp_valid <= adv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp <= core_rsp;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/osdm_checker.sv]
// ---------------------------------------------------------------------------
// osdm_checker
// Port-level checks on the deadline merger results, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "one_shot_deadline_merger_unit_macros.svh"

module osdm_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           rsp_valid,
  input wire logic           rsp_stall,
  input wire osdm_pkg::rsp_t rsp
);

  `OSDM_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall,
    rsp_valid && $stable(rsp))
  `OSDM_ASSERT_IMPLIES(a_no_write_zero, clk, rst, rsp_valid && !rsp.write_comparator,
    !rsp.comparator_armed && rsp.comparator_when == '0)
  `OSDM_ASSERT_IMPLIES(a_error_quiet, clk, rst,
    rsp_valid && rsp.status != osdm_pkg::ST_OK,
    !rsp.write_comparator && !rsp.timer_due && !rsp.preempt_due)
  `OSDM_ASSERT_IMPLIES(a_write_live, clk, rst, rsp_valid && rsp.write_comparator,
    rsp.live_armed == rsp.comparator_armed && rsp.live_when == rsp.comparator_when)
  `OSDM_ASSERT_IMPLIES(a_disarmed_zero, clk, rst, rsp_valid && !rsp.live_armed,
    rsp.live_when == '0)

endmodule

bind one_shot_deadline_merger_unit osdm_checker u_osdm_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire
